@@ design/fpta_pkg.sv @@
// ----------------------------------------------------------------------------
// fpta_pkg: shared definitions of the first passage time accumulator
// Types, register indexes and widths that the front, the queue, the back
// and the top level use.
// ----------------------------------------------------------------------------
package fpta_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DistW  = 24;
  localparam int unsigned HalfW  = 23;
  localparam int unsigned SumW   = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned PendW  = 56;
  localparam int unsigned PcntW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgAbsorb  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEscape  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMode    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHalf    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMinPass = 3'd4;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_CLEAR,
    OP_CROSS,
    OP_BIN
  } fpta_op_e;

  typedef struct packed {
    logic signed [DistW-1:0] absorb_level;
    logic signed [DistW-1:0] escape_level;
    logic                    count_mode;
    logic [HalfW-1:0]        bin_half_width;
  } fpta_cfg_t;

  typedef struct packed {
    fpta_op_e         op;
    logic             boundary;
    logic             hit_escape;
    logic             hit_open;
    logic             hit_leave;
    logic [TimeW-1:0] stamp;
  } fpta_item_t;

endpackage

@@ design/fpta_front.sv @@
// ----------------------------------------------------------------------------
// fpta_front: sample intake and classification
// Tracks the previous time stamp, detects trajectory boundaries and
// compares the distance against the configured levels.
// ----------------------------------------------------------------------------
module fpta_front import fpta_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fpta_cfg_t               cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [TimeW-1:0]        sample_time_i,
  input  logic signed [DistW-1:0] sample_distance_i,
  input  logic                    full_i,
  output logic                    push_o,
  output fpta_item_t              item_o
);

  logic [TimeW-1:0] prev_time_q, prev_time_d;
  logic             seen_q, seen_d;
  logic             up;
  logic signed [DistW:0] d_x, a_x, e_x, h_x, esc_margin, bin_lo, bin_hi;

  function automatic logic beyond(logic signed [DistW:0] x, logic signed [DistW:0] lvl,
                                  logic dir_up);
    beyond = dir_up ? (x > lvl) : (x < lvl);
  endfunction

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign up   = cfg_i.escape_level > cfg_i.absorb_level;
  assign d_x  = {sample_distance_i[DistW-1], sample_distance_i};
  assign a_x  = {cfg_i.absorb_level[DistW-1], cfg_i.absorb_level};
  assign e_x  = {cfg_i.escape_level[DistW-1], cfg_i.escape_level};
  assign h_x  = {2'b00, cfg_i.bin_half_width};
  assign esc_margin = e_x - h_x;
  assign bin_lo     = a_x - h_x;
  assign bin_hi     = a_x + h_x;

  always_comb begin
    item_o.stamp      = sample_time_i;
    item_o.boundary   = seen_q && (sample_time_i < prev_time_q);
    item_o.hit_leave  = beyond(d_x, a_x, up);
    if (cfg_i.count_mode) begin
      item_o.hit_escape = beyond(d_x, esc_margin, up);
      item_o.hit_open   = (d_x > bin_lo) && (d_x < bin_hi);
    end else begin
      item_o.hit_escape = beyond(d_x, e_x, up);
      item_o.hit_open   = beyond(a_x, d_x, up);
    end
    if (!seen_q) begin
      item_o.op = OP_SKIP;
    end else if (cfg_i.absorb_level == cfg_i.escape_level) begin
      item_o.op = OP_CLEAR;
    end else if (cfg_i.count_mode) begin
      item_o.op = OP_BIN;
    end else begin
      item_o.op = OP_CROSS;
    end
  end

  always_comb begin
    prev_time_d = prev_time_q;
    seen_d      = seen_q;
    if (push_o) begin
      prev_time_d = sample_time_i;
      seen_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      seen_q      <= 1'b0;
    end else begin
      prev_time_q <= prev_time_d;
      seen_q      <= seen_d;
    end
  end

endmodule

@@ design/fpta_queue.sv @@
// ----------------------------------------------------------------------------
// fpta_queue: two-entry queue between front and back
// Lets the front keep accepting while the back waits on its receiver.
// ----------------------------------------------------------------------------
module fpta_queue import fpta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fpta_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       nonempty_o,
  output fpta_item_t item_o
);

  fpta_item_t  entry_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o     = count_q == 2'd2;
  assign nonempty_o = count_q != 2'd0;
  assign item_o     = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ design/fpta_back.sv @@
// ----------------------------------------------------------------------------
// fpta_back: passage tracking and accumulation pipeline
// Stage A updates the passage state, stage B multiplies span by start
// count, stage C forms and qualifies the passage sum, and the output stage
// updates the saturating totals.
// ----------------------------------------------------------------------------
module fpta_back import fpta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SumW-1:0]     min_passage_i,
  input  logic                nonempty_i,
  input  fpta_item_t          item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                passage_closed_o,
  output logic [SumW-1:0]     passage_sum_o,
  output logic [SumW-1:0]     total_time_o,
  output logic [CountW-1:0]   total_count_o
);

  logic              en;
  logic              ip_q, ip_d, ia_q, ia_d;
  logic [PendW-1:0]  ps_q, ps_d;
  logic [PcntW-1:0]  pc_q, pc_d;
  logic [TimeW-1:0]  st_q, st_d;

  logic              ip0, ia0, rec, close;
  logic [PendW-1:0]  ps0;
  logic [PcntW-1:0]  pc0;
  logic [TimeW-1:0]  st0;
  logic [TimeW-1:0]  span;

  logic              a_valid_q, a_close_q;
  logic [TimeW-1:0]  a_span_q;
  logic [PcntW-1:0]  a_cnt_q;
  logic [PendW-1:0]  a_psum_q;

  logic              b_valid_q, b_close_q;
  logic [SumW-1:0]   b_prod_q;
  logic [PcntW-1:0]  b_cnt_q;
  logic [PendW-1:0]  b_psum_q;

  logic              c_valid_q, c_acc_q;
  logic [SumW-1:0]   c_res_q;
  logic [PcntW-1:0]  c_cnt_q;

  logic [PendW:0]    diff;
  logic [PendW-1:0]  pass;
  logic              accept;

  logic              out_valid_q, closed_q;
  logic [SumW-1:0]   psum_q, acc_time_q;
  logic [CountW-1:0] acc_cnt_q;
  logic [SumW:0]     time_sum;
  logic [CountW:0]   cnt_sum;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && nonempty_i;

  always_comb begin
    ip0 = item_i.boundary ? 1'b0 : ip_q;
    ia0 = item_i.boundary ? 1'b0 : ia_q;
    ps0 = item_i.boundary ? '0 : ps_q;
    pc0 = item_i.boundary ? '0 : pc_q;
    st0 = item_i.boundary ? '0 : st_q;
    ip_d  = ip0;
    ia_d  = ia0;
    st_d  = st0;
    rec   = 1'b0;
    close = 1'b0;
    case (item_i.op)
      OP_SKIP: begin
        ip_d = ip_q;
        ia_d = ia_q;
        st_d = st_q;
        ps0  = ps_q;
        pc0  = pc_q;
      end
      OP_CLEAR: begin
        ip_d = 1'b0;
        ia_d = 1'b0;
        st_d = '0;
        ps0  = '0;
        pc0  = '0;
      end
      OP_CROSS: begin
        if (ip0) begin
          if (item_i.hit_escape) begin
            close = 1'b1;
          end else if (ia0) begin
            if (item_i.hit_leave) begin
              rec  = 1'b1;
              ia_d = 1'b0;
            end
          end else if (item_i.hit_open) begin
            rec  = 1'b1;
            ia_d = 1'b1;
          end
        end else if (item_i.hit_open) begin
          ip_d = 1'b1;
          ia_d = 1'b1;
          st_d = '0;
          rec  = 1'b1;
        end
      end
      OP_BIN: begin
        if (ip0 && item_i.hit_escape) begin
          close = 1'b1;
        end else if (item_i.hit_open) begin
          if (!ip0) begin
            ip_d = 1'b1;
            st_d = item_i.stamp;
          end
          rec = 1'b1;
        end
      end
      default: begin
        ip_d = ip_q;
      end
    endcase
    ps_d = ps0;
    pc_d = pc0;
    if (rec && (pc0 != {PcntW{1'b1}})) begin
      pc_d = pc0 + PcntW'(1);
      ps_d = ps0 + {{(PendW-TimeW){1'b0}}, item_i.stamp - st_d};
    end
    if (close) begin
      ip_d = 1'b0;
      ia_d = 1'b0;
      st_d = '0;
      ps_d = '0;
      pc_d = '0;
    end
    span = (item_i.stamp >= st0) ? item_i.stamp - st0 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q <= 1'b0;
      ia_q <= 1'b0;
      ps_q <= '0;
      pc_q <= '0;
      st_q <= '0;
    end else if (pop_o) begin
      ip_q <= ip_d;
      ia_q <= ia_d;
      ps_q <= ps_d;
      pc_q <= pc_d;
      st_q <= st_d;
    end
  end

  assign diff   = {{(PendW-SumW+1){1'b0}}, b_prod_q} - {1'b0, b_psum_q};
  assign pass   = diff[PendW] ? '0 : diff[PendW-1:0];
  assign accept = b_close_q && ((pass[PendW-1:SumW] != '0) || (pass[SumW-1:0] > min_passage_i));

  assign time_sum = {1'b0, acc_time_q} + {1'b0, c_res_q};
  assign cnt_sum  = {1'b0, acc_cnt_q} + {{(CountW-PcntW+1){1'b0}}, c_cnt_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_close_q <= close;
      a_span_q  <= span;
      a_cnt_q   <= pc0;
      a_psum_q  <= ps0;
      b_close_q <= a_close_q;
      b_prod_q  <= SumW'(a_span_q) * SumW'(a_cnt_q);
      b_cnt_q   <= a_cnt_q;
      b_psum_q  <= a_psum_q;
      c_acc_q   <= accept;
      c_res_q   <= accept ? pass[SumW-1:0] : '0;
      c_cnt_q   <= accept ? b_cnt_q : '0;
      closed_q  <= c_acc_q;
      psum_q    <= c_res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_time_q  <= '0;
      acc_cnt_q   <= '0;
    end else if (en) begin
      a_valid_q   <= pop_o;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
      if (c_valid_q) begin
        acc_time_q <= time_sum[SumW] ? {SumW{1'b1}} : time_sum[SumW-1:0];
        acc_cnt_q  <= cnt_sum[CountW] ? {CountW{1'b1}} : cnt_sum[CountW-1:0];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign passage_closed_o = closed_q;
  assign passage_sum_o    = psum_q;
  assign total_time_o     = acc_time_q;
  assign total_count_o    = acc_cnt_q;

endmodule

@@ design/first_passage_time_accumulator.sv @@
// ----------------------------------------------------------------------------
// first_passage_time_accumulator: first passage time sums over trajectories
// Samples enter on the input channel (in_valid_i, in_stall_o) as a time
// stamp and a Q8.16 distance. Every accepted sample gives exactly one
// result transaction on the output channel (out_valid_o, out_stall_i)
// with the passage flag, the passage sum and the saturating totals.
// The block takes one sample per cycle while in_stall_o is low; the rate
// is set by the passage state update in the back end, with the span
// multiply and the total update in stages behind it. A two-entry queue
// separates the front from the back end; while the receiver stalls, the
// back end holds and the front keeps accepting until the queue is full,
// then raises in_stall_o. Reset clears all passage state and totals and
// restores the register defaults. Registers are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write them only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module first_passage_time_accumulator import fpta_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [TimeW-1:0]        sample_time_i,
  input  logic signed [DistW-1:0] sample_distance_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    passage_closed_o,
  output logic [SumW-1:0]         passage_sum_o,
  output logic [SumW-1:0]         total_time_o,
  output logic [CountW-1:0]       total_count_o
);

  fpta_cfg_t       cfg_q, cfg_d;
  logic [SumW-1:0] min_pass_q, min_pass_d;
  logic            push, full, pop, nonempty;
  fpta_item_t      front_item, queue_item;

  always_comb begin
    cfg_d      = cfg_q;
    min_pass_d = min_pass_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAbsorb:  cfg_d.absorb_level   = cfg_data_i[DistW-1:0];
        CfgEscape:  cfg_d.escape_level   = cfg_data_i[DistW-1:0];
        CfgMode:    cfg_d.count_mode     = cfg_data_i[0];
        CfgHalf:    cfg_d.bin_half_width = cfg_data_i[HalfW-1:0];
        CfgMinPass: min_pass_d           = cfg_data_i[SumW-1:0];
        default:    cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.absorb_level   <= '0;
      cfg_q.escape_level   <= 24'sd65536;
      cfg_q.count_mode     <= 1'b0;
      cfg_q.bin_half_width <= 23'd328;
      min_pass_q           <= '0;
    end else begin
      cfg_q      <= cfg_d;
      min_pass_q <= min_pass_d;
    end
  end

  fpta_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_time_i     (sample_time_i),
    .sample_distance_i (sample_distance_i),
    .full_i            (full),
    .push_o            (push),
    .item_o            (front_item)
  );

  fpta_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (front_item),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .item_o     (queue_item)
  );

  fpta_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .min_passage_i    (min_pass_q),
    .nonempty_i       (nonempty),
    .item_i           (queue_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .passage_closed_o (passage_closed_o),
    .passage_sum_o    (passage_sum_o),
    .total_time_o     (total_time_o),
    .total_count_o    (total_count_o)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: first passage time accumulator
// Drives trajectory samples through the input channel and checks every
// result transaction against a cycle-free predictor of the passage state and
// the saturating totals. Short directed trajectories cover both counting
// modes, both search directions, equal levels, trajectory boundaries and a
// mode change during an open passage. Random phases then vary the registers
// and the idling on both channels, and a final stretch of back-to-back
// crossings closes two long passages at the end of the time range.
// ----------------------------------------------------------------------------
module testbench;
  import fpta_pkg::*;

  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomPhases = 14;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned LongRun = 40;
  localparam logic ModeCross = 1'b0;
  localparam logic ModeBins = 1'b1;
  localparam longint One = 65536;
  localparam longint DistMax = 8388607;
  localparam longint DistMin = -8388608;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    logic [TimeW-1:0]        stamp;
    logic signed [DistW-1:0] distance;
  } sample_t;

  typedef struct {
    logic              closed;
    logic [SumW-1:0]   psum;
    logic [SumW-1:0]   ttime;
    logic [CountW-1:0] tcnt;
  } passage_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [TimeW-1:0]        sample_time_i = '0;
  logic signed [DistW-1:0] sample_distance_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    passage_closed_o;
  logic [SumW-1:0]         passage_sum_o;
  logic [SumW-1:0]         total_time_o;
  logic [CountW-1:0]       total_count_o;

  sample_t         pending_samples[$];
  passage_result_t expected_results[$];
  int unsigned     mismatch_count = 0;
  int unsigned     stuck_cycles = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  bit              sample_accepted = 1'b0;

  logic signed [DistW-1:0] cfg_absorb = '0;
  logic signed [DistW-1:0] cfg_escape = 24'sd65536;
  logic                    cfg_bin_mode = ModeCross;
  logic [HalfW-1:0]        cfg_half = 23'd328;
  logic [SumW-1:0]         cfg_min_passage = '0;

  logic [TimeW-1:0]  last_stamp = '0;
  bit                first_seen = 1'b0;
  bit                passage_open = 1'b0;
  bit                near_absorb = 1'b0;
  logic [PendW-1:0]  start_sum = '0;
  logic [PcntW-1:0]  start_count = '0;
  logic [TimeW-1:0]  origin_stamp = '0;
  logic [SumW-1:0]   total_time_q = '0;
  logic [CountW-1:0] total_count_q = '0;

  first_passage_time_accumulator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_time_i    (sample_time_i),
    .sample_distance_i(sample_distance_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .passage_closed_o (passage_closed_o),
    .passage_sum_o    (passage_sum_o),
    .total_time_o     (total_time_o),
    .total_count_o    (total_count_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic bit beyond(input longint x, input longint lvl, input bit up);
    return up ? (x > lvl) : (x < lvl);
  endfunction

  function automatic void drop_passage();
    passage_open = 1'b0;
    near_absorb = 1'b0;
    start_sum = '0;
    start_count = '0;
    origin_stamp = '0;
  endfunction

  function automatic void add_start(input logic [TimeW-1:0] stamp);
    logic [TimeW-1:0] gap;
    if (start_count != '1) begin
      gap = stamp - origin_stamp;
      start_count = start_count + PcntW'(1);
      start_sum = start_sum + PendW'(gap);
    end
  endfunction

  function automatic void close_passage(input logic [TimeW-1:0] stamp,
                                        inout passage_result_t res);
    logic [TimeW-1:0]  gap;
    logic [63:0]       span;
    logic [63:0]       whole;
    logic [63:0]       spent;
    logic [SumW:0]     time_sum;
    logic [CountW:0]   count_sum;
    gap = stamp - origin_stamp;
    span = (stamp >= origin_stamp) ? 64'(gap) : '0;
    whole = span * 64'(start_count);
    spent = (whole >= 64'(start_sum)) ? whole - 64'(start_sum) : '0;
    if (spent > 64'(cfg_min_passage)) begin
      res.closed = 1'b1;
      res.psum = spent[SumW-1:0];
      time_sum = {1'b0, total_time_q} + {1'b0, spent[SumW-1:0]};
      total_time_q = time_sum[SumW] ? '1 : time_sum[SumW-1:0];
      count_sum = {1'b0, total_count_q} + (CountW+1)'(start_count);
      total_count_q = count_sum[CountW] ? '1 : count_sum[CountW-1:0];
    end
    drop_passage();
  endfunction

  function automatic passage_result_t predict_passage(input sample_t s);
    passage_result_t res;
    bit     up;
    longint d;
    longint abs_w;
    longint esc_w;
    longint half_w;
    res = '{closed: 1'b0, psum: '0, ttime: '0, tcnt: '0};
    d = longint'(s.distance);
    abs_w = longint'(cfg_absorb);
    esc_w = longint'(cfg_escape);
    half_w = longint'(cfg_half);
    if (!first_seen) begin
      first_seen = 1'b1;
      last_stamp = s.stamp;
    end else begin
      if (s.stamp < last_stamp) drop_passage();
      last_stamp = s.stamp;
      if (abs_w == esc_w) begin
        drop_passage();
      end else begin
        up = esc_w > abs_w;
        if (cfg_bin_mode == ModeCross) begin
          if (passage_open) begin
            if (beyond(d, esc_w, up)) begin
              close_passage(s.stamp, res);
            end else if (near_absorb) begin
              if (beyond(d, abs_w, up)) begin
                add_start(s.stamp);
                near_absorb = 1'b0;
              end
            end else if (beyond(abs_w, d, up)) begin
              add_start(s.stamp);
              near_absorb = 1'b1;
            end
          end else if (beyond(abs_w, d, up)) begin
            passage_open = 1'b1;
            near_absorb = 1'b1;
            origin_stamp = '0;
            add_start(s.stamp);
          end
        end else begin
          if (passage_open && beyond(d, esc_w - half_w, up)) begin
            close_passage(s.stamp, res);
          end else if (d > abs_w - half_w && d < abs_w + half_w) begin
            if (!passage_open) begin
              passage_open = 1'b1;
              origin_stamp = s.stamp;
            end
            add_start(s.stamp);
          end
        end
      end
    end
    res.ttime = total_time_q;
    res.tcnt = total_count_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic push_sample(input logic [TimeW-1:0] stamp,
                             input logic signed [DistW-1:0] distance);
    sample_t s;
    s.stamp = stamp;
    s.distance = distance;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IdleNone: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IdleSender: begin
        send_idle_pct = 58;
        recv_stall_pct = 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct = 12;
        recv_stall_pct = 12;
      end
    endcase
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAbsorb:  cfg_absorb = value[DistW-1:0];
      CfgEscape:  cfg_escape = value[DistW-1:0];
      CfgMode:    cfg_bin_mode = value[0];
      CfgHalf:    cfg_half = value[HalfW-1:0];
      CfgMinPass: cfg_min_passage = value[SumW-1:0];
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || sample_accepted)) begin
      sample_accepted = 1'b0;
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_time_i <= pending_samples[0].stamp;
        sample_distance_i <= pending_samples[0].distance;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.insert(expected_results.size(),
                              predict_passage(pending_samples.pop_front()));
      sample_accepted = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    passage_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (passage_closed_o !== want.closed)
          report_mismatch($sformatf("passage_closed got %b expected %b",
                                    passage_closed_o, want.closed));
        if (passage_sum_o !== want.psum)
          report_mismatch($sformatf("passage_sum got %h expected %h",
                                    passage_sum_o, want.psum));
        if (total_time_o !== want.ttime)
          report_mismatch($sformatf("total_time got %h expected %h",
                                    total_time_o, want.ttime));
        if (total_count_o !== want.tcnt)
          report_mismatch($sformatf("total_count got %h expected %h",
                                    total_count_o, want.tcnt));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic signed [DistW-1:0] lvl_a;
    logic signed [DistW-1:0] lvl_e;
    logic signed [DistW-1:0] r24;
    logic [HalfW-1:0]        half;
    logic [SumW-1:0]         min_pass;
    logic [TimeW-1:0]        stamp;
    longint                  abs_w;
    longint                  esc_w;
    longint                  half_w;
    longint                  side;
    longint                  lo;
    longint                  hi;
    longint                  d_w;
    int unsigned             made;
    int unsigned             traj_len;
    int unsigned             pick;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Crossing mode, upward search, register defaults.
    set_idling(IdleNone);
    push_sample(32'd100, 24'sd0);
    push_sample(32'd110, -24'sd100);
    push_sample(32'd120, 24'sd500);
    push_sample(32'd130, -24'sd5);
    push_sample(32'd200, 24'sh7FFFFF);
    push_sample(32'd50, 24'sh800000);
    push_sample(32'd0, 24'sd0);
    push_sample(32'hFFFF_FFFF, -24'sd1);
    push_sample(32'hFFFF_FFFF, 24'sh7FFFFF);
    push_sample(32'd16, -24'sd1);
    push_sample(32'd20, 24'sd1);
    wait_idle();

    // The passage opened above continues under bin counting.
    write_register(CfgMode, {47'($urandom()), ModeBins});
    set_idling(IdleBoth);
    push_sample(32'd30, 24'sd327);
    push_sample(32'd31, 24'sd328);
    push_sample(32'd32, -24'sd327);
    push_sample(32'd33, 24'sd65208);
    push_sample(32'd40, 24'sd65209);
    push_sample(32'd50, 24'sd0);
    push_sample(32'd60, 24'sd100);
    push_sample(32'd10, 24'sd5000);
    push_sample(32'd13, 24'sd70000);
    wait_idle();

    // Downward search with a minimum passage.
    write_register(CfgAbsorb, {24'($urandom()), 24'sd65536});
    write_register(CfgEscape, {24'($urandom()), -24'sd65536});
    write_register(CfgHalf, {25'($urandom()), 23'd1000});
    write_register(CfgMinPass, 48'd100);
    write_register(CfgMode, {47'($urandom()), ModeCross});
    set_idling(IdleReceiver);
    push_sample(32'd5, 24'sd70000);
    push_sample(32'd8, 24'sd60000);
    push_sample(32'd9, -24'sd65537);
    push_sample(32'd10, 24'sd65537);
    push_sample(32'd500, -24'sd70000);
    wait_idle();

    // Equal levels count nothing.
    write_register(CfgEscape, {24'($urandom()), 24'sd65536});
    set_idling(IdleSender);
    push_sample(32'd600, 24'sd0);
    push_sample(32'd700, 24'sd65536);
    push_sample(32'd100, 24'sh800000);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_idle();
      case (ph % 6)
        0: begin
          lvl_a = 24'sd0;
          lvl_e = 24'sd65536;
        end
        1: begin
          lvl_a = 24'sd65536;
          lvl_e = -24'sd65536;
        end
        2: begin
          lvl_a = DistW'($urandom());
          lvl_e = DistW'($urandom());
        end
        3: begin
          lvl_a = 24'sh800000;
          lvl_e = 24'sh7FFFFF;
        end
        4: begin
          lvl_a = 24'sh7FFFFF;
          lvl_e = 24'sh800000;
        end
        default: begin
          lvl_a = DistW'($urandom());
          lvl_e = lvl_a;
        end
      endcase
      case (ph % 5)
        0: half = 23'd328;
        1: half = '0;
        2: half = HalfW'($urandom_range(1, 4000));
        3: half = '1;
        default: half = HalfW'($urandom());
      endcase
      case (ph % 7)
        2: min_pass = SumW'($urandom_range(0, 2000));
        3: min_pass = SumW'({$urandom(), $urandom()});
        4: min_pass = '1;
        6: min_pass = SumW'($urandom_range(0, 100000));
        default: min_pass = '0;
      endcase
      write_register(CfgAbsorb, {24'($urandom()), lvl_a});
      write_register(CfgEscape, {24'($urandom()), lvl_e});
      write_register(CfgHalf, {25'($urandom()), half});
      write_register(CfgMinPass, min_pass);
      write_register(CfgMode, {47'($urandom()), 1'($urandom_range(0, 1))});
      set_idling(idle_mode_e'(ph % 4));

      abs_w = longint'(cfg_absorb);
      esc_w = longint'(cfg_escape);
      half_w = longint'(cfg_half);
      side = (esc_w > abs_w) ? 1 : -1;
      lo = (abs_w < esc_w) ? abs_w : esc_w;
      hi = (abs_w < esc_w) ? esc_w : abs_w;
      made = 0;
      while (made < ItemsPerPhase) begin
        stamp = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 5000);
        traj_len = $urandom_range(3, 40);
        for (int k = 0; k < traj_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            d_w = abs_w - half_w - 2 + longint'($urandom_range(0, 32'(2 * half_w + 4)));
          end else if (pick < 50) begin
            d_w = abs_w - side * longint'($urandom_range(1, 70000));
          end else if (pick < 70) begin
            d_w = lo + longint'($urandom_range(0, 32'(hi - lo)));
          end else if (pick < 85) begin
            d_w = esc_w + side * longint'($urandom_range(0, 70000));
          end else if (pick < 93) begin
            case ($urandom_range(0, 3))
              0: d_w = abs_w;
              1: d_w = esc_w;
              2: d_w = esc_w - half_w + longint'($urandom_range(0, 2)) - 1;
              default: d_w = abs_w + (($urandom_range(0, 1) == 0) ? half_w : -half_w);
            endcase
          end else begin
            r24 = DistW'($urandom());
            d_w = longint'(r24);
          end
          if (d_w > DistMax) d_w = DistMax;
          if (d_w < DistMin) d_w = DistMin;
          push_sample(stamp, d_w[DistW-1:0]);
          made++;
          pick = $urandom_range(0, 99);
          if (pick < 3) stamp = $urandom();
          else if (pick < 8) stamp = stamp + $urandom();
          else if (pick >= 30) stamp = stamp + $urandom_range(1, 300);
        end
      end
    end
    wait_idle();

    // Back-to-back crossings close two passages at the end of the time range.
    write_register(CfgAbsorb, 48'd0);
    write_register(CfgEscape, 48'(One));
    write_register(CfgMode, {47'd0, ModeCross});
    write_register(CfgMinPass, 48'd0);
    set_idling(IdleNone);
    for (int rep = 0; rep < 2; rep++) begin
      push_sample(32'd0, 24'sd0);
      for (int k = 0; k < LongRun; k++)
        push_sample(32'd1, (k % 2 == 0) ? -24'sd1 : 24'sd1);
      push_sample(32'hFFFF_FFFF, 24'sh7FFFFF);
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
